// ===== sv/tec_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tec_pkg
// Shared types and codes of the triangle edge contact unit: configuration
// register indexes, edge codes and the control structs of the edge pipeline.
// ----------------------------------------------------------------------------
package tec_pkg;

    localparam int CFG_INDEX_WIDTH = 3;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_VERTEX_A_X,
        CFG_VERTEX_A_Y,
        CFG_VERTEX_B_X,
        CFG_VERTEX_B_Y,
        CFG_VERTEX_C_X,
        CFG_VERTEX_C_Y,
        CFG_CONTACT_CUTOFF
    } tec_cfg_t;

    typedef enum logic [1:0] {
        EDGE_AB,
        EDGE_AC,
        EDGE_BC
    } tec_edge_t;

    typedef struct packed {
        logic      valid;
        tec_edge_t edge_id;
    } tec_edge_job_t;

    typedef struct packed {
        logic      valid;
        tec_edge_t edge_id;
        logic      c_pos;
        logic      c_neg;
        logic      contact;
    } tec_edge_res_t;

endpackage
`default_nettype wire

// ===== sv/tec_point_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tec_point_if
// Query point channel: valid/ready handshake with the point coordinates.
// ----------------------------------------------------------------------------
interface tec_point_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;

    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface
`default_nettype wire

// ===== sv/tec_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tec_result_if
// Contact result channel: valid/ready handshake with one result item.
// ----------------------------------------------------------------------------
interface tec_result_if #(
    parameter int COORD_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic                          is_inside;
    logic                          contact_valid;
    logic [1:0]                    edge_index;
    logic [COORD_WIDTH-2:0]        edge_distance;
    logic signed [COORD_WIDTH-1:0] delta_x;
    logic signed [COORD_WIDTH-1:0] delta_y;
    logic                          last_result;

    modport source (
        output valid, output is_inside, output contact_valid, output edge_index,
        output edge_distance, output delta_x, output delta_y, output last_result,
        input ready
    );
    modport sink (
        input valid, input is_inside, input contact_valid, input edge_index,
        input edge_distance, input delta_x, input delta_y, input last_result,
        output ready
    );
endinterface
`default_nettype wire

// ===== sv/tec_edge_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tec_edge_unit
// Pipelined edge evaluation: cross product, squared length, split products,
// then one bit per stage of the distance root and of both delta quotients.
// ----------------------------------------------------------------------------
module tec_edge_unit
    import tec_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire tec_edge_job_t                 job,
    input  wire logic signed [COORD_WIDTH-1:0] px,
    input  wire logic signed [COORD_WIDTH-1:0] py,
    input  wire logic signed [COORD_WIDTH-1:0] ux,
    input  wire logic signed [COORD_WIDTH-1:0] uy,
    input  wire logic signed [COORD_WIDTH-1:0] vx,
    input  wire logic signed [COORD_WIDTH-1:0] vy,
    input  wire logic [COORD_WIDTH-2:0]        cutoff,
    output tec_edge_res_t                      res,
    output logic [COORD_WIDTH-2:0]             edge_dist,
    output logic [COORD_WIDTH-1:0]             dlt_x,
    output logic [COORD_WIDTH-1:0]             dlt_y
);

    localparam int W   = COORD_WIDTH;
    localparam int HW  = W + 1;
    localparam int MW  = 2 * HW;
    localparam int SW  = 2 * MW;
    localparam int NW  = MW + HW;
    localparam int DB  = W - 1;
    localparam int NST = DB + 6;

    typedef struct packed {
        logic signed [HW-1:0] wx;
        logic signed [HW-1:0] wy;
        logic signed [HW-1:0] dx;
        logic signed [HW-1:0] dy;
    } st1_t;

    typedef struct packed {
        logic signed [MW-1:0] p1;
        logic signed [MW-1:0] p2;
        logic signed [MW-1:0] q1;
        logic signed [MW-1:0] q2;
        logic signed [HW-1:0] dx;
        logic signed [HW-1:0] dy;
    } st2_t;

    typedef struct packed {
        logic [MW-1:0] c_mag;
        logic [MW-1:0] len2;
        logic [HW-1:0] dx_mag;
        logic [HW-1:0] dy_mag;
        logic          c_pos;
        logic          c_neg;
        logic          dx_neg;
        logic          dy_neg;
    } st3_t;

    typedef struct packed {
        logic [MW-1:0] hh;
        logic [MW-1:0] hl;
        logic [MW-1:0] ll;
        logic [MW-1:0] xh;
        logic [MW-1:0] xl;
        logic [MW-1:0] yh;
        logic [MW-1:0] yl;
        logic [MW-1:0] len2;
        logic          c_pos;
        logic          c_neg;
        logic          x_neg;
        logic          y_neg;
    } st4_t;

    typedef struct packed {
        logic [SW-1:0] c2;
        logic [NW-1:0] nx;
        logic [NW-1:0] ny;
        logic [MW-1:0] len2;
        logic          c_pos;
        logic          c_neg;
        logic          x_neg;
        logic          y_neg;
    } st5_t;

    typedef struct packed {
        logic [SW-1:0] c2;
        logic [SW-1:0] s;
        logic [SW-1:0] t;
        logic [DB-1:0] d;
        logic [NW-1:0] rx;
        logic [NW-1:0] ry;
        logic [DB-1:0] qx;
        logic [DB-1:0] qy;
        logic [MW-1:0] len2;
        logic          dovf;
        logic          xovf;
        logic          yovf;
        logic          x_neg;
        logic          y_neg;
        logic          c_pos;
        logic          c_neg;
    } iter_t;

    logic      vld_reg [NST];
    logic      vld_next [NST];
    tec_edge_t eid_reg [NST];

    st1_t  st1_reg, st1_next;
    st2_t  st2_reg, st2_next;
    st3_t  st3_reg, st3_next;
    st4_t  st4_reg, st4_next;
    st5_t  st5_reg, st5_next;
    iter_t it_reg [DB+1];
    iter_t it0_next;

    logic signed [MW:0]   c_full;
    logic [MW:0]          c_abs;
    logic [HW-1:0]        ch;
    logic [HW-1:0]        cl;

    always_comb
    begin
        vld_next[0] = job.valid;
        for (int i = 1; i < NST; i++)
        begin
            vld_next[i] = vld_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            for (int i = 0; i < NST; i++)
            begin
                vld_reg[i] <= vld_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            eid_reg[0] <= job.edge_id;
            for (int i = 1; i < NST; i++)
            begin
                eid_reg[i] <= eid_reg[i-1];
            end
        end
    end

    // edge vectors
    always_comb
    begin
        st1_next.wx = {px[W-1], px} - {ux[W-1], ux};
        st1_next.wy = {py[W-1], py} - {uy[W-1], uy};
        st1_next.dx = {vx[W-1], vx} - {ux[W-1], ux};
        st1_next.dy = {vy[W-1], vy} - {uy[W-1], uy};
    end

    // products
    always_comb
    begin
        st2_next.p1 = st1_reg.dy * st1_reg.wx;
        st2_next.p2 = st1_reg.dx * st1_reg.wy;
        st2_next.q1 = st1_reg.dx * st1_reg.dx;
        st2_next.q2 = st1_reg.dy * st1_reg.dy;
        st2_next.dx = st1_reg.dx;
        st2_next.dy = st1_reg.dy;
    end

    // cross product and squared length
    always_comb
    begin
        c_full          = (MW+1)'(st2_reg.p1) - (MW+1)'(st2_reg.p2);
        c_abs           = c_full[MW] ? (MW+1)'(-c_full) : (MW+1)'(c_full);
        st3_next.c_mag  = c_abs[MW-1:0];
        st3_next.len2   = $unsigned(st2_reg.q1) + $unsigned(st2_reg.q2);
        st3_next.dx_mag = st2_reg.dx[HW-1] ? HW'(-st2_reg.dx) : HW'(st2_reg.dx);
        st3_next.dy_mag = st2_reg.dy[HW-1] ? HW'(-st2_reg.dy) : HW'(st2_reg.dy);
        st3_next.c_neg  = c_full[MW];
        st3_next.c_pos  = !c_full[MW] && (c_full != '0);
        st3_next.dx_neg = st2_reg.dx[HW-1];
        st3_next.dy_neg = st2_reg.dy[HW-1];
    end

    // split partial products
    always_comb
    begin
        ch             = st3_reg.c_mag[MW-1:HW];
        cl             = st3_reg.c_mag[HW-1:0];
        st4_next.hh    = ch * ch;
        st4_next.hl    = ch * cl;
        st4_next.ll    = cl * cl;
        st4_next.xh    = ch * st3_reg.dy_mag;
        st4_next.xl    = cl * st3_reg.dy_mag;
        st4_next.yh    = ch * st3_reg.dx_mag;
        st4_next.yl    = cl * st3_reg.dx_mag;
        st4_next.len2  = st3_reg.len2;
        st4_next.c_pos = st3_reg.c_pos;
        st4_next.c_neg = st3_reg.c_neg;
        st4_next.x_neg = (st3_reg.c_neg == st3_reg.dy_neg);
        st4_next.y_neg = (st3_reg.c_neg != st3_reg.dx_neg);
    end

    // partial product sums
    always_comb
    begin
        st5_next.c2    = (SW'(st4_reg.hh) << MW) + (SW'(st4_reg.hl) << (HW + 1))
                       + SW'(st4_reg.ll);
        st5_next.nx    = (NW'(st4_reg.xh) << HW) + NW'(st4_reg.xl);
        st5_next.ny    = (NW'(st4_reg.yh) << HW) + NW'(st4_reg.yl);
        st5_next.len2  = st4_reg.len2;
        st5_next.c_pos = st4_reg.c_pos;
        st5_next.c_neg = st4_reg.c_neg;
        st5_next.x_neg = st4_reg.x_neg;
        st5_next.y_neg = st4_reg.y_neg;
    end

    // saturation checks and start values
    always_comb
    begin
        it0_next.c2    = st5_reg.c2;
        it0_next.s     = '0;
        it0_next.t     = '0;
        it0_next.d     = '0;
        it0_next.rx    = st5_reg.nx;
        it0_next.ry    = st5_reg.ny;
        it0_next.qx    = '0;
        it0_next.qy    = '0;
        it0_next.len2  = st5_reg.len2;
        it0_next.dovf  = st5_reg.c2 >= (SW'(st5_reg.len2) << (2 * DB));
        it0_next.xovf  = st5_reg.nx >= (NW'(st5_reg.len2) << DB);
        it0_next.yovf  = st5_reg.ny >= (NW'(st5_reg.len2) << DB);
        it0_next.x_neg = st5_reg.x_neg;
        it0_next.y_neg = st5_reg.y_neg;
        it0_next.c_pos = st5_reg.c_pos;
        it0_next.c_neg = st5_reg.c_neg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            st1_reg   <= st1_next;
            st2_reg   <= st2_next;
            st3_reg   <= st3_next;
            st4_reg   <= st4_next;
            st5_reg   <= st5_next;
            it_reg[0] <= it0_next;
        end
    end

    // one root bit and one bit of each quotient per stage, msb first
    for (genvar j = 0; j < DB; j++)
    begin : g_iter
        localparam int K = DB - 1 - j;

        iter_t         step_next;
        logic [SW-1:0] s_cand;
        logic [NW-1:0] sub;

        always_comb
        begin
            step_next = it_reg[j];
            s_cand    = it_reg[j].s + (it_reg[j].t << (K + 1))
                      + (SW'(it_reg[j].len2) << (2 * K));
            sub       = NW'(it_reg[j].len2) << K;
            if (s_cand <= it_reg[j].c2)
            begin
                step_next.s    = s_cand;
                step_next.t    = it_reg[j].t + (SW'(it_reg[j].len2) << K);
                step_next.d[K] = 1'b1;
            end
            if (it_reg[j].rx >= sub)
            begin
                step_next.rx    = it_reg[j].rx - sub;
                step_next.qx[K] = 1'b1;
            end
            if (it_reg[j].ry >= sub)
            begin
                step_next.ry    = it_reg[j].ry - sub;
                step_next.qy[K] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                it_reg[j+1] <= step_next;
            end
        end
    end

    function automatic logic [W-1:0] sat_out(input logic ovf, input logic neg,
                                             input logic [DB-1:0] q);
        logic [W-1:0] r;
        if (ovf)
        begin
            r = neg ? {1'b1, {DB{1'b0}}} : {1'b0, {DB{1'b1}}};
        end
        else
        begin
            r = neg ? (W'(0) - {1'b0, q}) : {1'b0, q};
        end
        return r;
    endfunction

    always_comb
    begin
        edge_dist   = it_reg[DB].dovf ? {DB{1'b1}} : it_reg[DB].d;
        dlt_x       = sat_out(it_reg[DB].xovf, it_reg[DB].x_neg, it_reg[DB].qx);
        dlt_y       = sat_out(it_reg[DB].yovf, it_reg[DB].y_neg, it_reg[DB].qy);
        res.valid   = vld_reg[NST-1];
        res.edge_id = eid_reg[NST-1];
        res.c_pos   = it_reg[DB].c_pos;
        res.c_neg   = it_reg[DB].c_neg;
        res.contact = edge_dist < cutoff;
    end

endmodule
`default_nettype wire

// ===== sv/triangle_edge_contact_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_edge_contact_unit
// Inside test of a point against a configured triangle and edge contacts.
// ----------------------------------------------------------------------------
// A point is taken when idle or as the prior point's BC job issues and is
// split into edge jobs AB, AC and BC for one shared edge pipeline, one
// job per cycle while adv is high; it has COORD_WIDTH+5 stages, front stages
// then one per root and quotient bit. Results of a point are gathered once
// its BC job leaves and sent one per cycle, while result.ready is high, from
// a result buffer as the next point is in flight. The user must write vertices
// and cutoff via cfg_we/cfg_index/cfg_data while idle, unchecked by the unit.
module triangle_edge_contact_unit
    import tec_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_we,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [COORD_WIDTH-1:0]     cfg_data,
    tec_point_if.sink                       point,
    tec_result_if.source                    result
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = W - 1;

    logic signed [W-1:0] va_x_reg, va_y_reg, vb_x_reg, vb_y_reg, vc_x_reg, vc_y_reg;
    logic [DW-1:0]       cutoff_reg;

    logic                busy_reg, busy_next;
    tec_edge_t           sel_reg, sel_next;
    logic signed [W-1:0] px_reg, py_reg;
    logic signed [W-1:0] ux, uy, vx, vy;
    logic                adv;
    logic                in_fire;
    tec_edge_job_t       job;

    tec_edge_res_t       res;
    logic [DW-1:0]       res_dist;
    logic [W-1:0]        res_dx, res_dy;
    logic                res_take;
    logic                grp_load;
    logic                grp_ins;
    logic [2:0]          grp_mask;

    logic                col_ok_reg [2];
    logic                col_ct_reg [2];
    logic [DW-1:0]       col_dist_reg [2];
    logic [W-1:0]        col_dx_reg [2];
    logic [W-1:0]        col_dy_reg [2];

    logic                drn_busy_reg, drn_busy_next;
    logic [2:0]          drn_rem_reg, drn_rem_next;
    logic                drn_ins_reg;
    logic [DW-1:0]       drn_dist_reg [3];
    logic [W-1:0]        drn_dx_reg [3];
    logic [W-1:0]        drn_dy_reg [3];
    logic [1:0]          out_slot;
    logic [2:0]          out_low;
    logic                out_last;
    logic                out_fire;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_x_reg   <= '0;
            va_y_reg   <= '0;
            vb_x_reg   <= '0;
            vb_y_reg   <= '0;
            vc_x_reg   <= '0;
            vc_y_reg   <= '0;
            cutoff_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_VERTEX_A_X:     va_x_reg   <= cfg_data;
                CFG_VERTEX_A_Y:     va_y_reg   <= cfg_data;
                CFG_VERTEX_B_X:     vb_x_reg   <= cfg_data;
                CFG_VERTEX_B_Y:     vb_y_reg   <= cfg_data;
                CFG_VERTEX_C_X:     vc_x_reg   <= cfg_data;
                CFG_VERTEX_C_Y:     vc_y_reg   <= cfg_data;
                CFG_CONTACT_CUTOFF: cutoff_reg <= cfg_data[DW-1:0];
                default:            ;
            endcase
        end
    end

    // job issue: edges AB, AC and BC of each point
    assign point.ready = adv && (!busy_reg || sel_reg == EDGE_BC);
    assign in_fire     = point.valid && point.ready;
    assign job.valid   = busy_reg;
    assign job.edge_id = sel_reg;

    always_comb
    begin
        busy_next = busy_reg;
        sel_next  = sel_reg;
        if (in_fire)
        begin
            busy_next = 1'b1;
            sel_next  = EDGE_AB;
        end
        else if (adv && busy_reg)
        begin
            case (sel_reg)
                EDGE_AB: sel_next = EDGE_AC;
                EDGE_AC: sel_next = EDGE_BC;
                EDGE_BC: busy_next = 1'b0;
                default: busy_next = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        case (sel_reg)
            EDGE_AB:
            begin
                ux = va_x_reg; uy = va_y_reg; vx = vb_x_reg; vy = vb_y_reg;
            end
            EDGE_AC:
            begin
                ux = va_x_reg; uy = va_y_reg; vx = vc_x_reg; vy = vc_y_reg;
            end
            EDGE_BC:
            begin
                ux = vb_x_reg; uy = vb_y_reg; vx = vc_x_reg; vy = vc_y_reg;
            end
            default:
            begin
                ux = va_x_reg; uy = va_y_reg; vx = vb_x_reg; vy = vb_y_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sel_reg  <= EDGE_AB;
        end
        else
        begin
            busy_reg <= busy_next;
            sel_reg  <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            px_reg <= point.point_x;
            py_reg <= point.point_y;
        end
    end

    tec_edge_unit #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_edge (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .job       (job),
        .px        (px_reg),
        .py        (py_reg),
        .ux        (ux),
        .uy        (uy),
        .vx        (vx),
        .vy        (vy),
        .cutoff    (cutoff_reg),
        .res       (res),
        .edge_dist (res_dist),
        .dlt_x     (res_dx),
        .dlt_y     (res_dy)
    );

    // gather edges AB, AC and BC of a point; hold the pipe while a BC result meets a busy buffer
    assign out_fire = result.valid && result.ready;
    assign adv      = !(res.valid && res.edge_id == EDGE_BC && drn_busy_reg
                        && !(out_fire && out_last));
    assign res_take = res.valid && adv;
    assign grp_load = res_take && res.edge_id == EDGE_BC;
    assign grp_ins  = col_ok_reg[0] && col_ok_reg[1] && res.c_pos;
    assign grp_mask = grp_ins ? {res.contact, col_ct_reg[1], col_ct_reg[0]} : 3'b000;

    always_ff @(posedge clk)
    begin
        if (res_take && res.edge_id != EDGE_BC)
        begin
            col_ok_reg[res.edge_id == EDGE_AC]   <= (res.edge_id == EDGE_AC) ? res.c_neg
                                                                            : res.c_pos;
            col_ct_reg[res.edge_id == EDGE_AC]   <= res.contact;
            col_dist_reg[res.edge_id == EDGE_AC] <= res_dist;
            col_dx_reg[res.edge_id == EDGE_AC]   <= res_dx;
            col_dy_reg[res.edge_id == EDGE_AC]   <= res_dy;
        end
        if (grp_load)
        begin
            drn_ins_reg <= grp_ins;
            for (int i = 0; i < 2; i++)
            begin
                drn_dist_reg[i] <= col_dist_reg[i];
                drn_dx_reg[i]   <= col_dx_reg[i];
                drn_dy_reg[i]   <= col_dy_reg[i];
            end
            drn_dist_reg[2] <= res_dist;
            drn_dx_reg[2]   <= res_dx;
            drn_dy_reg[2]   <= res_dy;
        end
    end

    // result buffer: contacts in edge order, or one empty result
    always_comb
    begin
        if (drn_rem_reg[0])
        begin
            out_slot = 2'd0;
            out_low  = 3'b001;
        end
        else if (drn_rem_reg[1])
        begin
            out_slot = 2'd1;
            out_low  = 3'b010;
        end
        else
        begin
            out_slot = 2'd2;
            out_low  = 3'b100;
        end
        out_last = (drn_rem_reg & ~out_low) == 3'b000;
    end

    always_comb
    begin
        drn_busy_next = drn_busy_reg;
        drn_rem_next  = drn_rem_reg;
        if (out_fire)
        begin
            drn_rem_next = drn_rem_reg & ~out_low;
            if (out_last)
            begin
                drn_busy_next = 1'b0;
            end
        end
        if (grp_load)
        begin
            drn_busy_next = 1'b1;
            drn_rem_next  = grp_mask;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drn_busy_reg <= 1'b0;
            drn_rem_reg  <= 3'b000;
        end
        else
        begin
            drn_busy_reg <= drn_busy_next;
            drn_rem_reg  <= drn_rem_next;
        end
    end

    always_comb
    begin
        result.valid         = drn_busy_reg;
        result.is_inside     = drn_ins_reg;
        result.last_result   = out_last;
        result.contact_valid = drn_rem_reg != 3'b000;
        if (drn_rem_reg != 3'b000)
        begin
            result.edge_index    = out_slot;
            result.edge_distance = drn_dist_reg[out_slot];
            result.delta_x       = drn_dx_reg[out_slot];
            result.delta_y       = drn_dy_reg[out_slot];
        end
        else
        begin
            result.edge_index    = 2'd0;
            result.edge_distance = '0;
            result.delta_x       = '0;
            result.delta_y       = '0;
        end
    end

endmodule
`default_nettype wire

// ===== test/tb_triangle_edge_contact_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_edge_contact_unit
// Drives query points through the triangle edge contact unit under several
// triangle and cutoff settings. Point transfers are mostly scored by an exact
// wide-integer contact calculator; on the reset triangle a fixed outside
// result is expected. Every result transfer is compared field by field, in
// order, with what was expected. The point and result sides both stall at
// random, with one long stall on the result side.
// ----------------------------------------------------------------------------
module tb_triangle_edge_contact_unit;
    import tec_pkg::*;

    localparam int CW         = 32;
    localparam int DRAIN      = CW + 20;
    localparam int CYCLE_CAP  = 400000;
    localparam int HOLD_LEN   = 300;
    localparam int ONE        = 65536;

    typedef logic signed [191:0] wide_t;

    typedef struct {
        bit               is_inside;
        bit               contact_valid;
        bit [1:0]         edge_index;
        bit [CW-2:0]      edge_distance;
        bit [CW-1:0]      delta_x;
        bit [CW-1:0]      delta_y;
        bit               last_result;
    } contact_t;

    typedef struct {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
    } probe_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CW-1:0] cfg_data;

    tec_point_if  #(.COORD_WIDTH(CW)) point_if ();
    tec_result_if #(.COORD_WIDTH(CW)) result_if ();

    triangle_edge_contact_unit #(.COORD_WIDTH(CW)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .point     (point_if),
        .result    (result_if)
    );

    logic signed [CW-1:0] tri_x [3];
    logic signed [CW-1:0] tri_y [3];
    logic [CW-2:0]        cutoff;

    contact_t expected_contacts [$];
    int       mismatches;
    int       results_seen;
    int       cycles;

    probe_t probe_table [12];

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb_triangle_edge_contact_unit: FAIL");
            $finish;
        end
    end

    function automatic wide_t edge_cross(wide_t px, wide_t py, wide_t ux, wide_t uy,
                                         wide_t vx, wide_t vy);
        return (vy - uy) * (px - ux) - (vx - ux) * (py - uy);
    endfunction

    function automatic wide_t floor_root(wide_t n);
        wide_t r;
        wide_t cand;
        r = 0;
        for (int k = 80; k >= 0; k--)
        begin
            cand = r | (wide_t'(1) <<< k);
            if (cand * cand <= n)
                r = cand;
        end
        return r;
    endfunction

    function automatic bit [CW-1:0] clamp_delta(wide_t v);
        if (v > wide_t'(32'sh7fffffff))
            return 32'h7fffffff;
        if (v < -wide_t'(64'sh80000000))
            return 32'h80000000;
        return v[CW-1:0];
    endfunction

    task automatic score_edge(input tec_edge_t id, input wide_t px, input wide_t py,
                              input wide_t ux, input wide_t uy, input wide_t vx,
                              input wide_t vy, inout contact_t found [$]);
        wide_t    ex;
        wide_t    ey;
        wide_t    len2;
        wide_t    c;
        wide_t    root;
        contact_t hit;
        ex   = vx - ux;
        ey   = vy - uy;
        len2 = ex * ex + ey * ey;
        if (len2 == 0)
            return;
        c    = edge_cross(px, py, ux, uy, vx, vy);
        root = floor_root((c * c) / len2);
        if (root > wide_t'(32'h7fffffff))
            root = wide_t'(32'h7fffffff);
        if (!(root < wide_t'(cutoff)))
            return;
        hit.is_inside     = 1'b1;
        hit.contact_valid = 1'b1;
        hit.edge_index    = id;
        hit.edge_distance = root[CW-2:0];
        hit.delta_x       = clamp_delta((-(c * ey)) / len2);
        hit.delta_y       = clamp_delta((c * ex) / len2);
        hit.last_result   = 1'b0;
        found.push_back(hit);
    endtask

    task automatic predict_contacts(input logic signed [CW-1:0] qx,
                                    input logic signed [CW-1:0] qy);
        wide_t    px, py, ax, ay, bx, by, cx, cy;
        bit       ins;
        contact_t found [$];
        contact_t empty_res;
        px = wide_t'(qx); py = wide_t'(qy);
        ax = wide_t'(tri_x[0]); ay = wide_t'(tri_y[0]);
        bx = wide_t'(tri_x[1]); by = wide_t'(tri_y[1]);
        cx = wide_t'(tri_x[2]); cy = wide_t'(tri_y[2]);
        ins = edge_cross(px, py, ax, ay, bx, by) > 0 &&
              edge_cross(px, py, bx, by, cx, cy) > 0 &&
              edge_cross(px, py, cx, cy, ax, ay) > 0;
        if (ins)
        begin
            score_edge(EDGE_AB, px, py, ax, ay, bx, by, found);
            score_edge(EDGE_AC, px, py, ax, ay, cx, cy, found);
            score_edge(EDGE_BC, px, py, bx, by, cx, cy, found);
        end
        if (found.size() == 0)
        begin
            empty_res = '{default: 0};
            empty_res.is_inside = ins;
            found.push_back(empty_res);
        end
        found[found.size()-1].last_result = 1'b1;
        foreach (found[i])
            expected_contacts.push_back(found[i]);
    endtask

    task automatic write_reg(input tec_cfg_t idx, input logic [CW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic load_triangle(input logic signed [CW-1:0] ax, input logic signed [CW-1:0] ay,
                                 input logic signed [CW-1:0] bx, input logic signed [CW-1:0] by,
                                 input logic signed [CW-1:0] cx, input logic signed [CW-1:0] cy,
                                 input logic [CW-2:0] cut);
        tri_x[0] = ax; tri_y[0] = ay;
        tri_x[1] = bx; tri_y[1] = by;
        tri_x[2] = cx; tri_y[2] = cy;
        cutoff   = cut;
        write_reg(CFG_VERTEX_A_X, ax);
        write_reg(CFG_VERTEX_A_Y, ay);
        write_reg(CFG_VERTEX_B_X, bx);
        write_reg(CFG_VERTEX_B_Y, by);
        write_reg(CFG_VERTEX_C_X, cx);
        write_reg(CFG_VERTEX_C_Y, cy);
        write_reg(CFG_CONTACT_CUTOFF, {1'b0, cut});
    endtask

    task automatic wait_drained();
        while (expected_contacts.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    task automatic send_point(input logic signed [CW-1:0] qx, input logic signed [CW-1:0] qy,
                              input bit predicted, input contact_t typed);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            point_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        point_if.valid   <= 1'b1;
        point_if.point_x <= qx;
        point_if.point_y <= qy;
        do
            @(posedge clk);
        while (!point_if.ready);
        if (predicted)
            predict_contacts(qx, qy);
        else
            expected_contacts.push_back(typed);
    endtask

    task automatic stop_sending();
        point_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic signed [CW-1:0] rand_near(int span);
        return $signed($urandom_range(2 * span)) - span;
    endfunction

    task automatic random_phase(input int span, input int count, input bit wide_cut,
                                input bit pause_mid);
        logic signed [CW-1:0] v [6];
        logic signed [CW-1:0] t;
        wide_t                orient;
        logic [CW-2:0]        cut;
        contact_t             none;
        none = '{default: 0};
        for (int i = 0; i < 6; i++)
            v[i] = (span == 0) ? $signed($urandom()) : rand_near(span);
        orient = edge_cross(wide_t'(v[4]), wide_t'(v[5]), wide_t'(v[0]), wide_t'(v[1]),
                            wide_t'(v[2]), wide_t'(v[3]));
        if (orient < 0)
        begin
            t = v[2]; v[2] = v[4]; v[4] = t;
            t = v[3]; v[3] = v[5]; v[5] = t;
        end
        if (wide_cut)
            cut = 31'($urandom());
        else
            cut = 31'($urandom_range((span == 0) ? 32'h7fffffff : span));
        load_triangle(v[0], v[1], v[2], v[3], v[4], v[5], cut);
        for (int n = 0; n < count; n++)
        begin
            if (pause_mid && n == count / 2)
            begin
                stop_sending();
                while (expected_contacts.size() != 0)
                    @(posedge clk);
            end
            if ($urandom_range(9) < 7 && span != 0)
                send_point(rand_near(span), rand_near(span), 1'b1, none);
            else
                send_point($signed($urandom()), $signed($urandom()), 1'b1, none);
        end
        stop_sending();
        wait_drained();
    endtask

    // result side stalls, with one long hold-off while points keep coming
    initial
    begin
        bit held;
        int gap;
        held = 1'b0;
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held && results_seen >= 60 && point_if.valid)
            begin
                held = 1'b1;
                result_if.ready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            repeat ($urandom_range(12, 1)) @(posedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        contact_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            results_seen <= results_seen + 1;
            if (expected_contacts.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result transfer at cycle %0d", cycles);
            end
            else
            begin
                want = expected_contacts.pop_front();
                if (result_if.is_inside !== want.is_inside ||
                    result_if.contact_valid !== want.contact_valid ||
                    result_if.edge_index !== want.edge_index ||
                    result_if.edge_distance !== want.edge_distance ||
                    result_if.delta_x !== want.delta_x ||
                    result_if.delta_y !== want.delta_y ||
                    result_if.last_result !== want.last_result)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("mismatch cycle %0d: exp in=%0b cv=%0b e=%0d d=%h dx=%h dy=%h l=%0b got in=%0b cv=%0b e=%0d d=%h dx=%h dy=%h l=%0b",
                                 cycles, want.is_inside, want.contact_valid,
                                 want.edge_index, want.edge_distance, want.delta_x,
                                 want.delta_y, want.last_result, result_if.is_inside,
                                 result_if.contact_valid, result_if.edge_index,
                                 result_if.edge_distance, result_if.delta_x,
                                 result_if.delta_y, result_if.last_result);
                end
            end
        end
    end

    initial
    begin
        contact_t outside;
        mismatches       = 0;
        results_seen     = 0;
        cycles           = 0;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        point_if.valid   = 1'b0;
        point_if.point_x = '0;
        point_if.point_y = '0;
        tri_x = '{0, 0, 0};
        tri_y = '{0, 0, 0};
        cutoff = '0;

        probe_table = '{
            '{32'sh00000000, 32'sh00000000},
            '{32'sh7fffffff, 32'sh7fffffff},
            '{32'sh80000000, 32'sh80000000},
            '{32'sh80000000, 32'sh7fffffff},
            '{32'sh7fffffff, 32'sh80000000},
            '{10 * ONE, -10 * ONE},
            '{30 * ONE, -30 * ONE},
            '{2 * ONE, -50 * ONE},
            '{50 * ONE, -1 * ONE},
            '{48 * ONE, -49 * ONE},
            '{40 * ONE, 0},
            '{1, -1}
        };

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset triangle is degenerate: every point is outside
        outside = '{default: 0};
        outside.last_result = 1'b1;
        foreach (probe_table[i])
            send_point(probe_table[i].x, probe_table[i].y, 1'b0, outside);
        stop_sending();
        wait_drained();

        // right triangle, clockwise in the unit's sense, wide cutoff
        load_triangle(0, 0, 100 * ONE, 0, 0, -100 * ONE, 50 * ONE);
        foreach (probe_table[i])
            send_point(probe_table[i].x, probe_table[i].y, 1'b1, outside);
        stop_sending();
        wait_drained();

        // full range triangle, maximum cutoff, saturating distances
        load_triangle(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                      32'sh80000000, 32'sh80000000, 31'h7fffffff);
        foreach (probe_table[i])
            send_point(probe_table[i].x, probe_table[i].y, 1'b1, outside);
        stop_sending();
        wait_drained();

        random_phase(1 << 20, 16, 1'b0, 1'b0);
        random_phase(1 << 12, 12, 1'b0, 1'b1);
        random_phase(1 << 20, 16, 1'b0, 1'b0);
        random_phase(0, 8, 1'b1, 1'b0);
        random_phase(1 << 24, 12, 1'b0, 1'b0);
        random_phase(1 << 16, 10, 1'b1, 1'b0);

        if (mismatches == 0 && expected_contacts.size() == 0)
            $display("tb_triangle_edge_contact_unit: PASS");
        else
            $display("tb_triangle_edge_contact_unit: FAIL");
        $finish;
    end

endmodule
